// File: rtl/lah_pkg.sv
// shared constants, register codes and table builder for the look-ahead limiter
package lah_pkg;

  localparam int unsigned BLOCK_DEF        = 128;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned TANH_ENTRIES_DEF = 64;

  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned OUT_W   = 22;
  localparam int unsigned TANH_W  = 13;
  localparam int unsigned MAG_W   = 21;
  localparam int unsigned OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0] UNITY = 17'd65536;
  localparam logic [31:0] THRESH_Q   = 32'd1027604;
  localparam logic [47:0] CEIL_Q     = 48'd1043333;
  localparam logic [MAG_W-1:0] FULL_Q = 21'd1048576;
  localparam int unsigned SPAN_Q     = 5243;
  localparam int unsigned TANH_RANGE = 4;
  localparam int unsigned IDX_DEN    = TANH_RANGE * SPAN_Q;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(IDX_DEN) - 64'd1) / 64'(IDX_DEN);

  localparam int unsigned DIV_NW = 37;
  localparam logic [DIV_NW-1:0] REQ_NUM = DIV_NW'(THRESH_Q) << 16;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 8'd1;
  localparam logic [7:0]  BLOCK_LEN_RST = 8'd128;
  localparam logic [15:0] RELEASE_RST   = 16'd695;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(span * tanh(4 i / entries)) through an integer exp series
  function automatic logic [TANH_W-1:0] tanh_entry(input int unsigned i,
                                                   input int unsigned entries);
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] c;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    one  = 64'd1 << 30;
    x    = udiv64(64'(2 * TANH_RANGE) << 30, 64'(entries));
    term = one;
    e    = one;
    for (int unsigned k = 1; k <= 24; k++) begin
      term = udiv64((term * x) >> 30, 64'(k));
      e    = e + term;
    end
    c = udiv64((one << 30) + (e >> 1), e);
    p = one;
    for (int unsigned k = 0; k < i; k++) begin
      p = (p * c + (one >> 1)) >> 30;
    end
    num = 64'(SPAN_Q) * (one - p) * 64'd2 + (one + p);
    den = 64'd2 * (one + p);
    return TANH_W'(udiv64(num, den));
  endfunction

endpackage

// File: rtl/lah_mul.sv
// shared registered unsigned multiplier
module lah_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;
  logic [63:0] p_d;

  assign p_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;
endmodule

// File: rtl/lah_div.sv
// restoring divider, one quotient bit per cycle
module lah_div #(
  parameter int unsigned Nw = 37,
  parameter int unsigned Dw = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [Nw-1:0] dividend_i,
  input  logic [Dw-1:0] divisor_i,
  output logic          done_o,
  output logic [Nw-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(Nw + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [Nw-1:0] num_q, num_d;
  logic [Dw:0]   rem_q, rem_d;
  logic [Dw-1:0] dsr_q, dsr_d;
  logic [Dw:0]   shifted;

  always_comb begin
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    num_d   = num_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    shifted = {rem_q[Dw-1:0], num_q[Nw-1]};
    if (start_i && !busy_q) begin
      cnt_d  = CW'(Nw);
      busy_d = 1'b1;
      num_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = shifted - {1'b0, dsr_q};
        num_d = {num_q[Nw-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[Nw-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;
endmodule

// File: rtl/lah_buf.sv
// held and emitted block store, both ears in one word, with per-entry valid bits
module lah_buf #(
  parameter int unsigned Block = 128,
  parameter int unsigned Sw    = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic                 wr_en_i,
  input  logic [((Block > 1) ? $clog2(Block) : 1)-1:0] addr_i,
  input  logic [4*Sw-1:0]      wr_data_i,
  output logic [4*Sw-1:0]      rd_data_o
);
  logic [4*Sw-1:0] mem_q [Block];
  logic [Block-1:0] valid_q;
  logic [4*Sw-1:0] rd_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;
endmodule

// File: rtl/lookahead_block_limiter.sv
// stereo look-ahead block limiter, top level with sequencer
// path: S_RD, S_OUT if priming; else S_RD, S_GAIN, S_MUL, S_RND (S_IDX) per ear, S_OUT
// input: one word at a time; the sequencer uses the shared multiplier for the gain and
//   up to twice per ear, and runs up to two 37-step divides at a block end
// reset: asynchronous active low; buffers read as zero, gains at unity, first two
//   blocks play silence with tuser set
module lookahead_block_limiter #(
  parameter int unsigned Block       = lah_pkg::BLOCK_DEF,
  parameter int unsigned SampleWidth = lah_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned TanhEntries = lah_pkg::TANH_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_left, sample_right
  input  logic [((2*SampleWidth+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // limited_left, limited_right
  output logic [lah_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // priming
  output logic m_axis_tuser,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [lah_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lah_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lah_pkg::*;

  localparam int unsigned Sw = SampleWidth;
  localparam int unsigned KW = (Block > 1) ? $clog2(Block) : 1;
  localparam int unsigned TW = $clog2(TanhEntries);
  localparam logic [63:0] IDX_LIMIT = 64'(TanhEntries) * 64'(IDX_DEN);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_GAIN  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_RND   = 4'd4;
  localparam logic [3:0] S_IDX   = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;
  localparam logic [3:0] S_REQ   = 4'd7;
  localparam logic [3:0] S_REQW  = 4'd8;
  localparam logic [3:0] S_REL   = 4'd9;
  localparam logic [3:0] S_REL2  = 4'd10;
  localparam logic [3:0] S_STEP  = 4'd11;
  localparam logic [3:0] S_STEPW = 4'd12;

  function automatic logic [Sw-1:0] mag(input logic [Sw-1:0] v);
    return v[Sw-1] ? Sw'(-v) : v;
  endfunction

  function automatic logic [GAIN_W-1:0] gmin(input logic [GAIN_W-1:0] a,
                                             input logic [GAIN_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [TANH_W-1:0] tanh_rom [TanhEntries];
  for (genvar gi = 0; gi < TanhEntries; gi++) begin : g_tanh
    assign tanh_rom[gi] = tanh_entry(gi, TanhEntries);
  end

  logic [3:0]        state_q, state_d;
  logic [KW-1:0]     frame_q, frame_d;
  logic [KW-1:0]     k_q, k_d;
  logic [Sw-1:0]     in_l_q, in_l_d, in_r_q, in_r_d;
  logic              bend_q, bend_d;
  logic [Sw-2:0]     peak_q, peak_d;
  logic [GAIN_W-1:0] lim_q, lim_d, held_req_q, held_req_d, start_q, start_d;
  logic [GAIN_W-1:0] step_q, step_d, gain_q, gain_d, req_q, req_d, gend_q, gend_d;
  logic              step_neg_q, step_neg_d;
  logic [1:0]        seen_q, seen_d;
  logic [7:0]        blen_q, blen_d;
  logic [15:0]       coef_q, coef_d;
  logic              ear_q, ear_d;
  logic [OUT_W-1:0]  res_q [2];
  logic [OUT_W-1:0]  res_d [2];
  logic              prim_q, prim_d;
  logic              mv_q, mv_d;
  logic [OUT_W-1:0]  ol_q, ol_d, or_q, or_d;
  logic              ou_q, ou_d;

  logic [7:0]        len_eff;
  logic [Sw-1:0]     ml, mr_in, cur;
  logic [Sw-2:0]     pl, pr;
  logic              buf_rd, buf_wr;
  logic [4*Sw-1:0]   buf_rdata;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_q;
  logic [Sw-1:0]     div_den;
  logic signed [33:0] gs;
  logic [GAIN_W-1:0] glo, ghi, gnew;
  logic [47:0]       mround;
  logic [63:0]       nn;
  logic [MAG_W-1:0]  resm;
  logic              res_done;
  logic [TW-1:0]     tidx;

  lah_buf #(.Block(Block), .Sw(Sw)) u_lah_buf (
    .clk_i, .rst_ni,
    .rd_en_i   (buf_rd),
    .wr_en_i   (buf_wr),
    .addr_i    (buf_rd ? frame_q : k_q),
    .wr_data_i ({in_r_q, in_l_q, buf_rdata[4*Sw-1:2*Sw]}),
    .rd_data_o (buf_rdata)
  );

  lah_mul u_lah_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  lah_div #(.Nw(DIV_NW), .Dw(Sw)) u_lah_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    if (blen_q == 8'd0) begin
      len_eff = 8'd1;
    end else if (32'(blen_q) > 32'(Block)) begin
      len_eff = 8'(Block);
    end else begin
      len_eff = blen_q;
    end
  end

  always_comb begin
    state_d = state_q;  frame_d = frame_q;  k_d = k_q;
    in_l_d = in_l_q;  in_r_d = in_r_q;  bend_d = bend_q;  peak_d = peak_q;
    lim_d = lim_q;  held_req_d = held_req_q;  start_d = start_q;  step_d = step_q;
    step_neg_d = step_neg_q;  gain_d = gain_q;  req_d = req_q;  gend_d = gend_q;
    seen_d = seen_q;  blen_d = blen_q;  coef_d = coef_q;  ear_d = ear_q;
    res_d = res_q;  prim_d = prim_q;  mv_d = mv_q;
    ol_d = ol_q;  or_d = or_q;  ou_d = ou_q;
    buf_rd = 1'b0;  buf_wr = 1'b0;  mul_a = '0;  mul_b = '0;
    div_start = 1'b0;  div_num = '0;  div_den = '0;
    ml = '0;  mr_in = '0;  pl = '0;  pr = '0;  cur = '0;
    gs = '0;  glo = '0;  ghi = '0;  gnew = '0;
    mround = '0;  nn = '0;  resm = '0;  res_done = 1'b0;  tidx = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BLOCK_LEN:    blen_d = cfg_data_i[7:0];
        REG_RELEASE_COEF: coef_d = cfg_data_i;
        default: ;
      endcase
    end

    if (mv_q && m_axis_tready) begin
      mv_d = 1'b0;
    end

    cur = ear_q ? buf_rdata[2*Sw-1:Sw] : buf_rdata[Sw-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          in_l_d = s_axis_tdata[Sw-1:0];
          in_r_d = s_axis_tdata[2*Sw-1:Sw];
          k_d    = frame_q;
          buf_rd = 1'b1;
          bend_d = (16'(frame_q) + 16'd1) >= 16'(len_eff);
          ml     = mag(s_axis_tdata[Sw-1:0]);
          mr_in  = mag(s_axis_tdata[2*Sw-1:Sw]);
          pl     = ml[Sw-1] ? {(Sw-1){1'b1}} : ml[Sw-2:0];
          pr     = mr_in[Sw-1] ? {(Sw-1){1'b1}} : mr_in[Sw-2:0];
          if (pl > peak_d) peak_d = pl;
          if (pr > peak_d) peak_d = pr;
          state_d = S_RD;
        end
      end
      S_RD: begin
        buf_wr = 1'b1;
        if (seen_q < 2'd2) begin
          res_d[0] = '0;
          res_d[1] = '0;
          prim_d   = 1'b1;
          state_d  = S_OUT;
        end else begin
          prim_d  = 1'b0;
          mul_a   = 32'(step_q);
          mul_b   = 32'(k_q) + 32'd1;
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        glo = gmin(start_q, lim_q);
        ghi = (start_q < lim_q) ? lim_q : start_q;
        gs  = step_neg_q ? (34'(start_q) - 34'(prod[31:0]))
                         : (34'(start_q) + 34'(prod[31:0]));
        if (gs < $signed(34'(glo))) begin
          gnew = glo;
        end else if (gs > $signed(34'(ghi))) begin
          gnew = ghi;
        end else begin
          gnew = gs[GAIN_W-1:0];
        end
        gain_d  = gnew;
        ear_d   = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        mul_a   = 32'(mag(cur));
        mul_b   = 32'(gain_q);
        state_d = S_RND;
      end
      S_RND: begin
        mround = 48'((prod + 64'd32768) >> 16);
        if (mround <= CEIL_Q) begin
          resm     = MAG_W'(mround);
          res_done = 1'b1;
        end else begin
          nn = 64'(mround - CEIL_Q) * 64'(TanhEntries) + 64'(2 * SPAN_Q);
          if (nn >= IDX_LIMIT) begin
            resm     = FULL_Q;
            res_done = 1'b1;
          end else begin
            mul_a   = nn[31:0];
            mul_b   = RECIP[31:0];
            state_d = S_IDX;
          end
        end
      end
      S_IDX: begin
        tidx     = prod[RECIP_SHIFT +: TW];
        resm     = MAG_W'(CEIL_Q) + MAG_W'(tanh_rom[tidx]);
        res_done = 1'b1;
      end
      S_OUT: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          ol_d = res_q[0];
          or_d = res_q[1];
          ou_d = prim_q;
          if (bend_q) begin
            state_d = S_REQ;
          end else begin
            frame_d = KW'(32'(k_q) + 32'd1);
            state_d = S_IDLE;
          end
        end
      end
      S_REQ: begin
        if (32'(peak_q) > THRESH_Q) begin
          div_start = 1'b1;
          div_num   = REQ_NUM;
          div_den   = Sw'(peak_q);
          state_d   = S_REQW;
        end else begin
          req_d   = UNITY;
          state_d = S_REL;
        end
      end
      S_REQW: begin
        if (div_done) begin
          req_d   = div_q[GAIN_W-1:0];
          state_d = S_REL;
        end
      end
      S_REL: begin
        if (seen_q == 2'd0) begin
          held_req_d = req_q;
          seen_d     = 2'd1;
          peak_d     = '0;
          frame_d    = '0;
          state_d    = S_IDLE;
        end else if (req_q < lim_q) begin
          gend_d  = gmin(req_q, held_req_q);
          state_d = S_STEP;
        end else begin
          mul_a   = 32'(UNITY - lim_q);
          mul_b   = 32'(coef_q);
          state_d = S_REL2;
        end
      end
      S_REL2: begin
        gend_d  = gmin(gmin(lim_q + GAIN_W'(prod >> 16), req_q), held_req_q);
        state_d = S_STEP;
      end
      S_STEP: begin
        div_start = 1'b1;
        div_num   = DIV_NW'((gend_q > lim_q) ? (gend_q - lim_q) : (lim_q - gend_q));
        div_den   = Sw'(len_eff);
        state_d   = S_STEPW;
      end
      S_STEPW: begin
        if (div_done) begin
          step_d     = div_q[GAIN_W-1:0];
          step_neg_d = gend_q < lim_q;
          start_d    = lim_q;
          lim_d      = gend_q;
          held_req_d = req_q;
          seen_d     = 2'd2;
          peak_d     = '0;
          frame_d    = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (res_done) begin
      res_d[ear_q] = cur[Sw-1] ? OUT_W'(-OUT_W'(resm)) : OUT_W'(resm);
      if (!ear_q) begin
        ear_d   = 1'b1;
        state_d = S_MUL;
      end else begin
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      frame_q    <= '0;
      bend_q     <= 1'b0;
      peak_q     <= '0;
      lim_q      <= UNITY;
      held_req_q <= UNITY;
      start_q    <= UNITY;
      step_q     <= '0;
      step_neg_q <= 1'b0;
      seen_q     <= '0;
      blen_q     <= BLOCK_LEN_RST;
      coef_q     <= RELEASE_RST;
      ear_q      <= 1'b0;
      prim_q     <= 1'b0;
      mv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      frame_q    <= frame_d;
      bend_q     <= bend_d;
      peak_q     <= peak_d;
      lim_q      <= lim_d;
      held_req_q <= held_req_d;
      start_q    <= start_d;
      step_q     <= step_d;
      step_neg_q <= step_neg_d;
      seen_q     <= seen_d;
      blen_q     <= blen_d;
      coef_q     <= coef_d;
      ear_q      <= ear_d;
      prim_q     <= prim_d;
      mv_q       <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    in_l_q <= in_l_d;
    in_r_q <= in_r_d;
    gain_q <= gain_d;
    req_q  <= req_d;
    gend_q <= gend_d;
    res_q  <= res_d;
    ol_q   <= ol_d;
    or_q   <= or_d;
    ou_q   <= ou_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = OUT_TDATA_W'({or_q, ol_q});
  assign m_axis_tuser  = ou_q;
endmodule

// File: rtl/lah_chk.sv
// port-level checks for the look-ahead limiter, bound to the top level
module lah_chk #(
  parameter int unsigned SampleWidth = 24
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((2*SampleWidth+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [lah_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic m_axis_tuser
);
  import lah_pkg::*;

  // one word at a time through the sequencer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input word changed while waiting");

  a_priming_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("priming word not silent");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[OUT_W-1:0]) <= $signed(23'sd1048576) &&
      $signed(m_axis_tdata[OUT_W-1:0]) >= $signed(-23'sd1048576) &&
      $signed(m_axis_tdata[2*OUT_W-1:OUT_W]) <= $signed(23'sd1048576) &&
      $signed(m_axis_tdata[2*OUT_W-1:OUT_W]) >= $signed(-23'sd1048576))
    else $error("output above full scale");
endmodule

bind lookahead_block_limiter lah_chk #(.SampleWidth(SampleWidth)) u_lah_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
